[hw/rtl/dpbp_pkg.sv]
// shared types and constants for the depth pixel back-projection unit
// no dependencies; used by every module of the block
package dpbp_pkg;

    localparam int COORD_W        = 12;
    localparam int DEPTH_W        = 16;
    localparam int COLOR_W        = 8;
    localparam int FOCAL_W        = 24;
    localparam int CENTER_W       = 16;
    localparam int PICK_W         = 24;
    localparam int POINT_W        = 48;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;
    localparam int NUM_PICKS      = 3;
    localparam int SUBPIX_SHIFT   = 4;
    localparam int FRAC_SHIFT     = 20;
    localparam int COORD_BITS_DEF = 12;

    // offset d = 16*coord - center, signed
    localparam int OFFSET_W = CENTER_W + 2;
    // d * focal_inv (focal zero-extended)
    localparam int PROD1_W  = OFFSET_W + FOCAL_W + 1;
    // d * focal_inv * depth (depth zero-extended)
    localparam int PROD2_W  = PROD1_W + DEPTH_W + 1;

    localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic [FOCAL_W-1:0]  RST_FOCAL_INV_X = 24'd45599;
    localparam logic [FOCAL_W-1:0]  RST_FOCAL_INV_Y = 24'd45599;
    localparam logic [CENTER_W-1:0] RST_CENTER_X    = 16'd4067;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y    = 16'd3268;
    localparam logic [PICK_W-1:0]   RST_PICK_FIRST  = 24'd966898;
    localparam logic [PICK_W-1:0]   RST_PICK_SECOND = 24'd1171624;
    localparam logic [PICK_W-1:0]   RST_PICK_THIRD  = 24'd1437905;

    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_FOCAL_INV_X = 3'd0,
        IDX_FOCAL_INV_Y = 3'd1,
        IDX_CENTER_X    = 3'd2,
        IDX_CENTER_Y    = 3'd3,
        IDX_PICK_FIRST  = 3'd4,
        IDX_PICK_SECOND = 3'd5,
        IDX_PICK_THIRD  = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic [FOCAL_W-1:0]              focal_inv_x;
        logic [FOCAL_W-1:0]              focal_inv_y;
        logic [CENTER_W-1:0]             center_x;
        logic [CENTER_W-1:0]             center_y;
        logic [NUM_PICKS-1:0][PICK_W-1:0] pick;
    } t_cfg;

    // per-stage load enables
    typedef struct packed {
        logic s1_en;
        logic s2_en;
        logic s3_en;
    } t_pipe_ctrl;

endpackage

[hw/rtl/dpbp_cfg_regs.sv]
// configuration register file: intrinsics and the three pick coordinates
// depends on dpbp_pkg
module dpbp_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dpbp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dpbp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output dpbp_pkg::t_cfg                   o_cfg
);

    dpbp_pkg::t_cfg r_cfg;
    dpbp_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (dpbp_pkg::t_cfg_index'(i_cfg_index))
                dpbp_pkg::IDX_FOCAL_INV_X: begin
                    n_cfg.focal_inv_x = i_cfg_data[dpbp_pkg::FOCAL_W-1:0];
                end
                dpbp_pkg::IDX_FOCAL_INV_Y: begin
                    n_cfg.focal_inv_y = i_cfg_data[dpbp_pkg::FOCAL_W-1:0];
                end
                dpbp_pkg::IDX_CENTER_X: begin
                    n_cfg.center_x = i_cfg_data[dpbp_pkg::CENTER_W-1:0];
                end
                dpbp_pkg::IDX_CENTER_Y: begin
                    n_cfg.center_y = i_cfg_data[dpbp_pkg::CENTER_W-1:0];
                end
                dpbp_pkg::IDX_PICK_FIRST: begin
                    n_cfg.pick[0] = i_cfg_data[dpbp_pkg::PICK_W-1:0];
                end
                dpbp_pkg::IDX_PICK_SECOND: begin
                    n_cfg.pick[1] = i_cfg_data[dpbp_pkg::PICK_W-1:0];
                end
                dpbp_pkg::IDX_PICK_THIRD: begin
                    n_cfg.pick[2] = i_cfg_data[dpbp_pkg::PICK_W-1:0];
                end
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_inv_x <= dpbp_pkg::RST_FOCAL_INV_X;
            r_cfg.focal_inv_y <= dpbp_pkg::RST_FOCAL_INV_Y;
            r_cfg.center_x    <= dpbp_pkg::RST_CENTER_X;
            r_cfg.center_y    <= dpbp_pkg::RST_CENTER_Y;
            r_cfg.pick[0]     <= dpbp_pkg::RST_PICK_FIRST;
            r_cfg.pick[1]     <= dpbp_pkg::RST_PICK_SECOND;
            r_cfg.pick[2]     <= dpbp_pkg::RST_PICK_THIRD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/dpbp_offset_stage.sv]
// first pipeline stage: pick match, depth check and principal point offsets
// depends on dpbp_pkg
module dpbp_offset_stage #(
    parameter int COORD_BITS = dpbp_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  dpbp_pkg::t_cfg                       i_cfg,
    input  logic [dpbp_pkg::COORD_W-1:0]         i_pixel_row,
    input  logic [dpbp_pkg::COORD_W-1:0]         i_pixel_col,
    input  logic [dpbp_pkg::DEPTH_W-1:0]         i_depth_mm,
    output logic                                 o_hit,
    output logic signed [dpbp_pkg::OFFSET_W-1:0] o_dx,
    output logic signed [dpbp_pkg::OFFSET_W-1:0] o_dy
);

    localparam int CMP_BITS = (COORD_BITS < dpbp_pkg::COORD_W) ? COORD_BITS
                                                                 : dpbp_pkg::COORD_W;
    localparam logic [dpbp_pkg::COORD_W-1:0] CMASK =
        dpbp_pkg::COORD_W'((1 << CMP_BITS) - 1);

    logic [dpbp_pkg::COORD_W-1:0]   w_row;
    logic [dpbp_pkg::COORD_W-1:0]   w_col;
    logic [dpbp_pkg::NUM_PICKS-1:0] w_match;
    logic                           r_hit;
    logic signed [dpbp_pkg::OFFSET_W-1:0] r_dx;
    logic signed [dpbp_pkg::OFFSET_W-1:0] r_dy;
    logic signed [dpbp_pkg::OFFSET_W-1:0] n_dx;
    logic signed [dpbp_pkg::OFFSET_W-1:0] n_dy;

    assign w_row = i_pixel_row & CMASK;
    assign w_col = i_pixel_col & CMASK;

    // pick layout: row in the upper coordinate field, column in the lower
    always_comb begin
        for (int i = 0; i < dpbp_pkg::NUM_PICKS; i++) begin
            w_match[i] =
                ((i_cfg.pick[i][2*dpbp_pkg::COORD_W-1:dpbp_pkg::COORD_W] & CMASK) == w_row)
                && ((i_cfg.pick[i][dpbp_pkg::COORD_W-1:0] & CMASK) == w_col);
        end
    end

    // offsets in 1/16 pixel
    assign n_dx = $signed({2'b00, w_col, {dpbp_pkg::SUBPIX_SHIFT{1'b0}}})
                - $signed({2'b00, i_cfg.center_x});
    assign n_dy = $signed({2'b00, w_row, {dpbp_pkg::SUBPIX_SHIFT{1'b0}}})
                - $signed({2'b00, i_cfg.center_y});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= (|w_match) && (i_depth_mm != '0);
            r_dx  <= n_dx;
            r_dy  <= n_dy;
        end
    end

    assign o_hit = r_hit;
    assign o_dx  = r_dx;
    assign o_dy  = r_dy;

endmodule

[hw/rtl/dpbp_project_lane.sv]
// one axis of the projection: offset * focal_inv, then * depth, floor shift
// depends on dpbp_pkg; two stages, one multiplier each
module dpbp_project_lane (
    input  logic                                 i_clk,
    input  logic                                 i_en_s2,
    input  logic                                 i_en_s3,
    input  logic signed [dpbp_pkg::OFFSET_W-1:0] i_offset,
    input  logic [dpbp_pkg::FOCAL_W-1:0]         i_focal_inv,
    input  logic [dpbp_pkg::DEPTH_W-1:0]         i_depth_s2,
    input  logic                                 i_hit_s2,
    output logic signed [dpbp_pkg::POINT_W-1:0]  o_coord
);

    logic signed [dpbp_pkg::PROD1_W-1:0] w_prod1;
    logic signed [dpbp_pkg::PROD1_W-1:0] r_prod1;
    logic signed [dpbp_pkg::PROD2_W-1:0] w_prod2;
    logic signed [dpbp_pkg::POINT_W-1:0] w_coord;
    logic signed [dpbp_pkg::POINT_W-1:0] r_coord;

    assign w_prod1 = dpbp_pkg::PROD1_W'(i_offset)
                   * dpbp_pkg::PROD1_W'($signed({1'b0, i_focal_inv}));
    assign w_prod2 = dpbp_pkg::PROD2_W'(r_prod1)
                   * dpbp_pkg::PROD2_W'($signed({1'b0, i_depth_s2}));

    // dropping the fraction bits of a signed value rounds toward minus infinity
    assign w_coord = dpbp_pkg::POINT_W'(
        $signed(w_prod2[dpbp_pkg::PROD2_W-1:dpbp_pkg::FRAC_SHIFT]));

    always_ff @(posedge i_clk) begin
        if (i_en_s2) begin
            r_prod1 <= w_prod1;
        end
        if (i_en_s3) begin
            r_coord <= i_hit_s2 ? w_coord : '0;
        end
    end

    assign o_coord = r_coord;

endmodule

[hw/rtl/depth_pixel_backprojection_unit.sv]
// top level of the depth pixel back-projection unit: config, pipeline control
// depends on dpbp_pkg, dpbp_cfg_regs, dpbp_offset_stage, dpbp_project_lane
//
// Usage:
//   Input channel i_in_valid / o_in_stall carries one pixel per request:
//   row, column, depth in mm and BGR colour. Output channel o_out_valid /
//   i_out_stall carries one point per pixel, in input order: valid flag,
//   x and y in 1/256 mm, z in mm, colour and alpha.
//   Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data);
//   write it only while no request is in flight.
//   An accepted pixel passes through three register stages to the output:
//   the offset/pick stage, the offset * focal_inv multiply and the * depth
//   multiply, each stage holding one pixel. Throughput is one pixel per
//   cycle while the receiver does not stall.
//   A point is valid only for a picked pixel with nonzero depth; otherwise
//   all its fields are zero.
//   Reset clears the pipeline valid bits and loads the register defaults.
//   When the receiver stalls, the output holds its point and the stages
//   behind it fill their bubbles before o_in_stall rises.
module depth_pixel_backprojection_unit #(
    parameter int COORD_BITS = dpbp_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dpbp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dpbp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [dpbp_pkg::COORD_W-1:0]        i_pixel_row,
    input  logic [dpbp_pkg::COORD_W-1:0]        i_pixel_col,
    input  logic [dpbp_pkg::DEPTH_W-1:0]        i_depth_mm,
    input  logic [dpbp_pkg::COLOR_W-1:0]        i_blue,
    input  logic [dpbp_pkg::COLOR_W-1:0]        i_green,
    input  logic [dpbp_pkg::COLOR_W-1:0]        i_red,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_point_valid,
    output logic signed [dpbp_pkg::POINT_W-1:0] o_point_x,
    output logic signed [dpbp_pkg::POINT_W-1:0] o_point_y,
    output logic [dpbp_pkg::DEPTH_W-1:0]        o_point_z,
    output logic [dpbp_pkg::COLOR_W-1:0]        o_out_blue,
    output logic [dpbp_pkg::COLOR_W-1:0]        o_out_green,
    output logic [dpbp_pkg::COLOR_W-1:0]        o_out_red,
    output logic [dpbp_pkg::COLOR_W-1:0]        o_out_alpha
);

    dpbp_pkg::t_cfg       w_cfg;
    dpbp_pkg::t_pipe_ctrl w_ctrl;

    logic r_v1;
    logic r_v2;
    logic r_v3;

    logic                                 w_hit_s1;
    logic signed [dpbp_pkg::OFFSET_W-1:0] w_dx_s1;
    logic signed [dpbp_pkg::OFFSET_W-1:0] w_dy_s1;

    // side data that rides along with the multipliers
    logic [dpbp_pkg::DEPTH_W-1:0]   r_z1, r_z2, r_z3;
    logic [dpbp_pkg::COLOR_W-1:0]   r_b1, r_b2, r_b3;
    logic [dpbp_pkg::COLOR_W-1:0]   r_g1, r_g2, r_g3;
    logic [dpbp_pkg::COLOR_W-1:0]   r_r1, r_r2, r_r3;
    logic                           r_hit2, r_hit3;

    // a stage loads when it is empty or its contents move on
    assign w_ctrl.s3_en = !r_v3 || !i_out_stall;
    assign w_ctrl.s2_en = !r_v2 || w_ctrl.s3_en;
    assign w_ctrl.s1_en = !r_v1 || w_ctrl.s2_en;
    assign o_in_stall   = !w_ctrl.s1_en;

    dpbp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    dpbp_offset_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_offset (
        .i_clk       (i_clk),
        .i_en        (w_ctrl.s1_en),
        .i_cfg       (w_cfg),
        .i_pixel_row (i_pixel_row),
        .i_pixel_col (i_pixel_col),
        .i_depth_mm  (i_depth_mm),
        .o_hit       (w_hit_s1),
        .o_dx        (w_dx_s1),
        .o_dy        (w_dy_s1)
    );

    dpbp_project_lane u_lane_x (
        .i_clk       (i_clk),
        .i_en_s2     (w_ctrl.s2_en),
        .i_en_s3     (w_ctrl.s3_en),
        .i_offset    (w_dx_s1),
        .i_focal_inv (w_cfg.focal_inv_x),
        .i_depth_s2  (r_z2),
        .i_hit_s2    (r_hit2),
        .o_coord     (o_point_x)
    );

    dpbp_project_lane u_lane_y (
        .i_clk       (i_clk),
        .i_en_s2     (w_ctrl.s2_en),
        .i_en_s3     (w_ctrl.s3_en),
        .i_offset    (w_dy_s1),
        .i_focal_inv (w_cfg.focal_inv_y),
        .i_depth_s2  (r_z2),
        .i_hit_s2    (r_hit2),
        .o_coord     (o_point_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ctrl.s1_en) begin
                r_v1 <= i_in_valid;
            end
            if (w_ctrl.s2_en) begin
                r_v2 <= r_v1;
            end
            if (w_ctrl.s3_en) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.s1_en) begin
            r_z1 <= i_depth_mm;
            r_b1 <= i_blue;
            r_g1 <= i_green;
            r_r1 <= i_red;
        end
        if (w_ctrl.s2_en) begin
            r_z2   <= r_z1;
            r_b2   <= r_b1;
            r_g2   <= r_g1;
            r_r2   <= r_r1;
            r_hit2 <= w_hit_s1;
        end
        if (w_ctrl.s3_en) begin
            // non-picked or zero-depth pixels come out all zero
            r_z3   <= r_hit2 ? r_z2 : '0;
            r_b3   <= r_hit2 ? r_b2 : '0;
            r_g3   <= r_hit2 ? r_g2 : '0;
            r_r3   <= r_hit2 ? r_r2 : '0;
            r_hit3 <= r_hit2;
        end
    end

    assign o_out_valid   = r_v3;
    assign o_point_valid = r_hit3;
    assign o_point_z     = r_z3;
    assign o_out_blue    = r_b3;
    assign o_out_green   = r_g3;
    assign o_out_red     = r_r3;
    assign o_out_alpha   = r_hit3 ? dpbp_pkg::ALPHA_OPAQUE : '0;

endmodule

[hw/rtl/dpbp_checker.sv]
// port-level checker for the back-projection unit, bound to the top level
// depends on dpbp_pkg and depth_pixel_backprojection_unit
module dpbp_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic                                o_point_valid,
    input  logic signed [dpbp_pkg::POINT_W-1:0] o_point_x,
    input  logic signed [dpbp_pkg::POINT_W-1:0] o_point_y,
    input  logic [dpbp_pkg::DEPTH_W-1:0]        o_point_z,
    input  logic [dpbp_pkg::COLOR_W-1:0]        o_out_blue,
    input  logic [dpbp_pkg::COLOR_W-1:0]        o_out_green,
    input  logic [dpbp_pkg::COLOR_W-1:0]        o_out_red,
    input  logic [dpbp_pkg::COLOR_W-1:0]        o_out_alpha
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_point_x) && $stable(o_point_y)
            && $stable(o_point_z) && $stable(o_point_valid))
        else $error("stalled output point changed");

    // input is held back only when the output is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // a valid point has depth and an opaque alpha
    a_valid_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_point_valid |->
            o_point_z != '0 && o_out_alpha == dpbp_pkg::ALPHA_OPAQUE)
        else $error("valid point with zero depth or wrong alpha");

    // an invalid point is all zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_point_valid |->
            o_point_x == '0 && o_point_y == '0 && o_point_z == '0
            && o_out_blue == '0 && o_out_green == '0 && o_out_red == '0
            && o_out_alpha == '0)
        else $error("invalid point carries nonzero fields");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind depth_pixel_backprojection_unit dpbp_checker u_dpbp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_point_valid (o_point_valid),
    .o_point_x     (o_point_x),
    .o_point_y     (o_point_y),
    .o_point_z     (o_point_z),
    .o_out_blue    (o_out_blue),
    .o_out_green   (o_out_green),
    .o_out_red     (o_out_red),
    .o_out_alpha   (o_out_alpha)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// self-checking bench for depth_pixel_backprojection_unit: random pixel stream with idling
// on both channels, points predicted in-bench and compared field by field
// depends on dpbp_pkg and the depth_pixel_backprojection_unit rtl
module tb_top;

    localparam int COORD_W    = dpbp_pkg::COORD_W;
    localparam int DEPTH_W    = dpbp_pkg::DEPTH_W;
    localparam int COLOR_W    = dpbp_pkg::COLOR_W;
    localparam int POINT_W    = dpbp_pkg::POINT_W;
    localparam int CFG_IDX_W  = dpbp_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = dpbp_pkg::CFG_DATA_W;
    localparam int CENTER_W   = dpbp_pkg::CENTER_W;
    localparam int PICK_W     = dpbp_pkg::PICK_W;
    localparam int NUM_PICKS  = dpbp_pkg::NUM_PICKS;
    localparam int COORD_BITS = dpbp_pkg::COORD_BITS_DEF;
    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((1 << COORD_BITS) - 1);
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PER_PHASE = 135;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_pixel;

    typedef struct packed {
        logic               is_valid;
        logic [POINT_W-1:0] x;
        logic [POINT_W-1:0] y;
        logic [DEPTH_W-1:0] z;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] alpha;
    } t_point;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [COORD_W-1:0]    i_pixel_row = '0;
    logic [COORD_W-1:0]    i_pixel_col = '0;
    logic [DEPTH_W-1:0]    i_depth_mm = '0;
    logic [COLOR_W-1:0]    i_blue = '0;
    logic [COLOR_W-1:0]    i_green = '0;
    logic [COLOR_W-1:0]    i_red = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_point_valid;
    logic signed [POINT_W-1:0] o_point_x;
    logic signed [POINT_W-1:0] o_point_y;
    logic [DEPTH_W-1:0]    o_point_z;
    logic [COLOR_W-1:0]    o_out_blue;
    logic [COLOR_W-1:0]    o_out_green;
    logic [COLOR_W-1:0]    o_out_red;
    logic [COLOR_W-1:0]    o_out_alpha;

    dpbp_pkg::t_cfg cfg_shadow;
    t_pixel pending_pixels[$];
    t_point expected_points[$];
    t_pixel drive_px;
    t_point got_pt;
    t_point want_pt;
    int     in_gap = 0;
    int     out_hold = 0;
    bit     in_burst = 1'b0;
    bit     out_burst = 1'b0;
    int     mismatch_count = 0;
    int     idle_cycles = 0;

    depth_pixel_backprojection_unit #(
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_pixel_row(i_pixel_row),
        .i_pixel_col(i_pixel_col),
        .i_depth_mm(i_depth_mm),
        .i_blue(i_blue),
        .i_green(i_green),
        .i_red(i_red),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_point_valid(o_point_valid),
        .o_point_x(o_point_x),
        .o_point_y(o_point_y),
        .o_point_z(o_point_z),
        .o_out_blue(o_out_blue),
        .o_out_green(o_out_green),
        .o_out_red(o_out_red),
        .o_out_alpha(o_out_alpha)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // pinhole back-projection of one pixel against the shadow registers
    function automatic t_point backproject_pixel(input t_pixel px);
        t_point             pt;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               hit;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic signed [63:0] prod;
        pt = '0;
        row = px.row & COORD_MASK;
        col = px.col & COORD_MASK;
        hit = 1'b0;
        for (int i = 0; i < NUM_PICKS; i++) begin
            if (((cfg_shadow.pick[i][23:12] & COORD_MASK) == row) &&
                ((cfg_shadow.pick[i][11:0] & COORD_MASK) == col)) begin
                hit = 1'b1;
            end
        end
        if (hit && px.depth != '0) begin
            dx = {48'd0, col, 4'b0000};
            dx = dx - {48'd0, cfg_shadow.center_x};
            dy = {48'd0, row, 4'b0000};
            dy = dy - {48'd0, cfg_shadow.center_y};
            // arithmetic shift gives floor for negative products
            prod = dx * $signed({40'd0, cfg_shadow.focal_inv_x}) * $signed({48'd0, px.depth});
            prod = prod >>> dpbp_pkg::FRAC_SHIFT;
            pt.x = prod[POINT_W-1:0];
            prod = dy * $signed({40'd0, cfg_shadow.focal_inv_y}) * $signed({48'd0, px.depth});
            prod = prod >>> dpbp_pkg::FRAC_SHIFT;
            pt.y = prod[POINT_W-1:0];
            pt.is_valid = 1'b1;
            pt.z = px.depth;
            pt.blue = px.blue;
            pt.green = px.green;
            pt.red = px.red;
            pt.alpha = dpbp_pkg::ALPHA_OPAQUE;
        end
        return pt;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            dpbp_pkg::IDX_FOCAL_INV_X: cfg_shadow.focal_inv_x = data;
            dpbp_pkg::IDX_FOCAL_INV_Y: cfg_shadow.focal_inv_y = data;
            dpbp_pkg::IDX_CENTER_X:    cfg_shadow.center_x = data[CENTER_W-1:0];
            dpbp_pkg::IDX_CENTER_Y:    cfg_shadow.center_y = data[CENTER_W-1:0];
            dpbp_pkg::IDX_PICK_FIRST:  cfg_shadow.pick[0] = data;
            dpbp_pkg::IDX_PICK_SECOND: cfg_shadow.pick[1] = data;
            dpbp_pkg::IDX_PICK_THIRD:  cfg_shadow.pick[2] = data;
            default: ;
        endcase
    endtask

    // sampled away from the rising edge so driver and monitor updates have settled
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_pixels.size() != 0 || i_in_valid || expected_points.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic load_config(input logic [23:0] fx, input logic [23:0] fy,
                               input logic [23:0] cx, input logic [23:0] cy,
                               input logic [23:0] p0, input logic [23:0] p1,
                               input logic [23:0] p2);
        wait_idle();
        write_reg(dpbp_pkg::IDX_FOCAL_INV_X, fx);
        write_reg(dpbp_pkg::IDX_FOCAL_INV_Y, fy);
        write_reg(dpbp_pkg::IDX_CENTER_X, cx);
        write_reg(dpbp_pkg::IDX_CENTER_Y, cy);
        write_reg(dpbp_pkg::IDX_PICK_FIRST, p0);
        write_reg(dpbp_pkg::IDX_PICK_SECOND, p1);
        write_reg(dpbp_pkg::IDX_PICK_THIRD, p2);
        // out-of-range index must leave every register alone
        write_reg(IDX_UNUSED, 24'($urandom));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_pixel(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
                              input logic [DEPTH_W-1:0] depth, input logic [COLOR_W-1:0] b,
                              input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] r);
        t_pixel px;
        px.row = row;
        px.col = col;
        px.depth = depth;
        px.blue = b;
        px.green = g;
        px.red = r;
        pending_pixels.push_back(px);
    endtask

    // every pick at full depth, then the same spot with no depth measurement
    task automatic push_pick_cases();
        for (int i = 0; i < NUM_PICKS; i++) begin
            push_pixel(cfg_shadow.pick[i][23:12], cfg_shadow.pick[i][11:0], 16'hFFFF,
                       8'hFF, 8'h00, 8'hA5);
            push_pixel(cfg_shadow.pick[i][23:12], cfg_shadow.pick[i][11:0], 16'h0000,
                       8'h5A, 8'hFF, 8'h00);
        end
    endtask

    task automatic push_random(input int n);
        logic [PICK_W-1:0] spot;
        int                sel;
        int                bit_sel;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            spot = cfg_shadow.pick[$urandom_range(0, NUM_PICKS - 1)];
            if (sel >= 70) begin
                spot = 24'($urandom);
            end else if (sel >= 55) begin
                // near miss: one coordinate bit off a pick
                bit_sel = $urandom_range(0, PICK_W - 1);
                spot[bit_sel] = ~spot[bit_sel];
            end
            sel = $urandom_range(0, 99);
            push_pixel(spot[23:12], spot[11:0],
                       (sel < 10) ? 16'd0 : (sel < 15) ? 16'hFFFF : (sel < 20) ? 16'd1 :
                       16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        end
    endtask

    // driver: one request at a time, random gap before each
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_points.push_back(backproject_pixel(drive_px));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap = in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    drive_px = pending_pixels.pop_front();
                    i_pixel_row <= drive_px.row;
                    i_pixel_col <= drive_px.col;
                    i_depth_mm <= drive_px.depth;
                    i_blue <= drive_px.blue;
                    i_green <= drive_px.green;
                    i_red <= drive_px.red;
                    i_in_valid <= 1'b1;
                    if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
                    in_gap = in_burst ? 0 : $urandom_range(0, 16);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each accepted point, then draw the stall for the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got_pt = {o_point_valid, o_point_x, o_point_y, o_point_z, o_out_blue,
                          o_out_green, o_out_red, o_out_alpha};
                if (expected_points.size() == 0) begin
                    $display("%0t: point with no request pending, expected none, actual %h",
                             $time, got_pt);
                    mismatch_count++;
                end else begin
                    want_pt = expected_points.pop_front();
                    check_field("point_valid", 64'(want_pt.is_valid), 64'(got_pt.is_valid));
                    check_field("point_x", 64'(want_pt.x), 64'(got_pt.x));
                    check_field("point_y", 64'(want_pt.y), 64'(got_pt.y));
                    check_field("point_z", 64'(want_pt.z), 64'(got_pt.z));
                    check_field("out_blue", 64'(want_pt.blue), 64'(got_pt.blue));
                    check_field("out_green", 64'(want_pt.green), 64'(got_pt.green));
                    check_field("out_red", 64'(want_pt.red), 64'(got_pt.red));
                    check_field("out_alpha", 64'(want_pt.alpha), 64'(got_pt.alpha));
                end
                if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
                out_hold = out_burst ? 0 : $urandom_range(0, 16);
            end else if (o_out_valid && out_hold > 0) begin
                out_hold = out_hold - 1;
            end
            i_out_stall <= (out_hold != 0);
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("depth_pixel_backprojection_unit verification failed");
        $finish;
    end

    initial begin
        cfg_shadow.focal_inv_x = dpbp_pkg::RST_FOCAL_INV_X;
        cfg_shadow.focal_inv_y = dpbp_pkg::RST_FOCAL_INV_Y;
        cfg_shadow.center_x = dpbp_pkg::RST_CENTER_X;
        cfg_shadow.center_y = dpbp_pkg::RST_CENTER_Y;
        cfg_shadow.pick[0] = dpbp_pkg::RST_PICK_FIRST;
        cfg_shadow.pick[1] = dpbp_pkg::RST_PICK_SECOND;
        cfg_shadow.pick[2] = dpbp_pkg::RST_PICK_THIRD;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults
        push_pick_cases();
        push_pixel(12'd0, 12'd0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        push_pixel(12'hFFF, 12'hFFF, 16'd1, 8'h00, 8'h00, 8'h00);
        push_random(RANDOM_PER_PHASE);

        // largest positive offsets at full focal
        load_config(24'hFFFFFF, 24'hFFFFFF, 24'h0, 24'h0, 24'hFFFFFF, 24'hFFF000, 24'h000FFF);
        push_pick_cases();
        push_random(RANDOM_PER_PHASE);

        // largest negative offsets, duplicated picks, center high bits dropped
        load_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h0, 24'h0, 24'hFFF000);
        push_pick_cases();
        push_random(RANDOM_PER_PHASE);

        // zero focal: valid points on the optical axis only
        load_config(24'h0, 24'h0, 24'($urandom), 24'($urandom), 24'($urandom),
                    24'($urandom), 24'($urandom));
        push_random(RANDOM_PER_PHASE);

        for (int ph = 0; ph < 5; ph++) begin
            load_config(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                        24'($urandom), 24'($urandom), 24'($urandom));
            push_random(RANDOM_PER_PHASE);
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_points.size() == 0) begin
            $display("depth_pixel_backprojection_unit verification clean");
        end else begin
            $display("depth_pixel_backprojection_unit verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/dpbp_pkg.sv
hw/rtl/dpbp_cfg_regs.sv
hw/rtl/dpbp_offset_stage.sv
hw/rtl/dpbp_project_lane.sv
hw/rtl/depth_pixel_backprojection_unit.sv
hw/rtl/dpbp_checker.sv
tb/tb_top.sv
